// ===== src/cro_pkg.sv =====
`timescale 1ns / 1ps

package cro_pkg;

	// Geometry and fixed point
	localparam int COORD_BITS     = 12;
	localparam int DIST_FRAC_BITS = 4;
	localparam int RAD_BITS       = 10;
	localparam int CHAN_BITS      = 8;
	localparam int CHAN_MAX       = 255;

	// Window reach is radius + 4, so every squared term fits in REACH_BITS
	localparam int REACH_BITS = RAD_BITS + 1;
	localparam int CMP_BITS   = (COORD_BITS > REACH_BITS) ? COORD_BITS : REACH_BITS;
	localparam int SQ_BITS    = 2 * REACH_BITS;
	localparam int SUM_BITS   = SQ_BITS + 1;
	localparam int ROOT_BITS  = (SUM_BITS + 2 * DIST_FRAC_BITS + 1) / 2;
	localparam int RAD_N_BITS = 2 * ROOT_BITS;
	localparam int REM_BITS   = ROOT_BITS + 2;

	// Root stages: a few digits per stage
	localparam int ITER_PER_STAGE = 4;
	localparam int SQRT_STAGES    = (ROOT_BITS + ITER_PER_STAGE - 1) / ITER_PER_STAGE;

	// Stroke shape in distance units
	localparam int HALF_STROKE = 5 << (DIST_FRAC_BITS - 2);
	localparam int FEATHER     = 2 << DIST_FRAC_BITS;
	localparam int FADE_BITS   = DIST_FRAC_BITS + 2;

	// Stream widths
	localparam int IN_FIELD_BITS = 2 * COORD_BITS + 4 * CHAN_BITS;
	localparam int IN_DATA_W     = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W    = 4 * CHAN_BITS;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X,
		CFG_CENTER_Y,
		CFG_RING_RADIUS,
		CFG_RING_RED,
		CFG_RING_GREEN,
		CFG_RING_BLUE
	} cfg_idx_t;

	typedef enum logic [1:0] {
		BL_PASS,
		BL_FULL,
		BL_MIX
	} blend_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0] alpha;
		logic [CHAN_BITS-1:0] blue;
		logic [CHAN_BITS-1:0] green;
		logic [CHAN_BITS-1:0] red;
	} pix_t;

	// Digit-by-digit root state: radicand bits still to feed, remainder, root
	typedef struct packed {
		logic [RAD_N_BITS-1:0] rad;
		logic [REM_BITS-1:0]   rem;
		logic [ROOT_BITS-1:0]  root;
	} sqrt_t;

	// One restoring root digit
	function automatic sqrt_t sqrt_step(input sqrt_t st);
		logic [REM_BITS+1:0] cur;
		logic [REM_BITS+1:0] trial;
		sqrt_t nx;
		cur   = {st.rem, st.rad[RAD_N_BITS-1 -: 2]};
		trial = (REM_BITS + 2)'({st.root, 2'b01});
		nx.rad = {st.rad[RAD_N_BITS-3:0], 2'b00};
		if (cur >= trial) begin
			nx.rem  = REM_BITS'(cur - trial);
			nx.root = {st.root[ROOT_BITS-2:0], 1'b1};
		end else begin
			nx.rem  = REM_BITS'(cur);
			nx.root = {st.root[ROOT_BITS-2:0], 1'b0};
		end
		return nx;
	endfunction

	// Digits of one root stage; the last stage may run short
	function automatic sqrt_t sqrt_stage(input sqrt_t st, input int first);
		sqrt_t cur;
		cur = st;
		for (int i = 0; i < ITER_PER_STAGE; i++) begin
			if (first + i < ROOT_BITS) begin
				cur = sqrt_step(cur);
			end
		end
		return cur;
	endfunction

	// Floor of x / 255 for x below 255 * 256
	function automatic logic [CHAN_BITS-1:0] div255(input logic [2*CHAN_BITS-1:0] x);
		logic [2*CHAN_BITS:0] t;
		t = (2 * CHAN_BITS + 1)'(x) + (2 * CHAN_BITS + 1)'(x >> CHAN_BITS)
			+ (2 * CHAN_BITS + 1)'(1);
		return CHAN_BITS'(t >> CHAN_BITS);
	endfunction

endpackage

// ===== src/cursor_ring_overlay_top.sv =====
`timescale 1ns / 1ps
// Throughput: one pixel per clock while the output is not stalled; the radius root runs
// four digits per stage over four stages, with squaring, blend multiply and the divide
// by 255 in stages of their own. A stalled output backs up stage by stage; empty stages
// keep filling meanwhile.
// Reset (arst_n low, asynchronous) clears every stage valid bit and sets the
// ring registers to centre 0,0, radius 16 and colour black.

module cursor_ring_overlay_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// cfg: register index and write data
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cro_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cro_pkg::CFG_DATA_W-1:0]   cfg_data,
	// s_tdata, low bit up: pix_x, pix_y, in_red, in_green, in_blue, in_alpha
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [cro_pkg::IN_DATA_W-1:0]    s_tdata,
	// m_tdata, low bit up: out_red, out_green, out_blue, out_alpha
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [cro_pkg::OUT_DATA_W-1:0]   m_tdata
);

	localparam int CB      = cro_pkg::COORD_BITS;
	localparam int CW      = cro_pkg::CHAN_BITS;
	localparam int S_DIFF  = 1;
	localparam int S_SQ    = 2;
	localparam int S_SUM   = 3;
	localparam int S_ROOT  = 4;
	localparam int S_ALPHA = S_ROOT + cro_pkg::SQRT_STAGES;
	localparam int S_MIX   = S_ALPHA + 1;
	localparam int STAGES  = S_MIX + 1;

	// Ring registers
	logic [CB-1:0]                  center_x_q;
	logic [CB-1:0]                  center_y_q;
	logic [cro_pkg::RAD_BITS-1:0]   ring_radius_q;
	logic [CW-1:0]                  ring_red_q;
	logic [CW-1:0]                  ring_green_q;
	logic [CW-1:0]                  ring_blue_q;

	assign cfg_ready = 1'b1;

	// Write a ring register; unknown indexes do nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= '0;
			center_y_q    <= '0;
			ring_radius_q <= cro_pkg::RAD_BITS'(16);
			ring_red_q    <= '0;
			ring_green_q  <= '0;
			ring_blue_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cro_pkg::cfg_idx_t'(cfg_index))
				cro_pkg::CFG_CENTER_X:    center_x_q    <= CB'(cfg_data);
				cro_pkg::CFG_CENTER_Y:    center_y_q    <= CB'(cfg_data);
				cro_pkg::CFG_RING_RADIUS: ring_radius_q <= cro_pkg::RAD_BITS'(cfg_data);
				cro_pkg::CFG_RING_RED:    ring_red_q    <= CW'(cfg_data);
				cro_pkg::CFG_RING_GREEN:  ring_green_q  <= CW'(cfg_data);
				cro_pkg::CFG_RING_BLUE:   ring_blue_q   <= CW'(cfg_data);
				default: ;
			endcase
		end
	end

	// Stage handshake: a stage loads when it is empty or its content moves on
	logic [STAGES:1] valid_q;
	logic [STAGES:1] en;

	always_comb begin
		en[STAGES] = ~valid_q[STAGES] | m_tready;
		for (int k = STAGES - 1; k >= 1; k--) begin
			en[k] = ~valid_q[k] | en[k+1];
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = valid_q[STAGES];

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[1]) begin
				valid_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	// Unpack the input request
	logic [CB-1:0]   in_x;
	logic [CB-1:0]   in_y;
	cro_pkg::pix_t   in_pix;

	assign in_x         = s_tdata[CB-1:0];
	assign in_y         = s_tdata[2*CB-1:CB];
	assign in_pix.red   = s_tdata[2*CB+CW-1:2*CB];
	assign in_pix.green = s_tdata[2*CB+2*CW-1:2*CB+CW];
	assign in_pix.blue  = s_tdata[2*CB+3*CW-1:2*CB+2*CW];
	assign in_pix.alpha = s_tdata[2*CB+4*CW-1:2*CB+3*CW];

	// Pixel and window flag travel with the item
	cro_pkg::pix_t pix_q [1:STAGES-1];
	logic          far_q [1:S_ALPHA-1];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pix_q[1] <= in_pix;
		end
		for (int k = 2; k <= STAGES - 1; k++) begin
			if (en[k]) begin
				pix_q[k] <= pix_q[k-1];
			end
		end
	end

	// Stage 1: offsets from centre and window test
	logic [CB-1:0]                    dx_c;
	logic [CB-1:0]                    dy_c;
	logic [cro_pkg::REACH_BITS-1:0]   reach_c;
	logic [CB-1:0]                    dx_s1;
	logic [CB-1:0]                    dy_s1;

	always_comb begin
		dx_c    = (in_x >= center_x_q) ? in_x - center_x_q : center_x_q - in_x;
		dy_c    = (in_y >= center_y_q) ? in_y - center_y_q : center_y_q - in_y;
		reach_c = cro_pkg::REACH_BITS'(ring_radius_q) + cro_pkg::REACH_BITS'(4);
	end

	always_ff @(posedge clk) begin
		if (en[S_DIFF]) begin
			dx_s1    <= dx_c;
			dy_s1    <= dy_c;
			far_q[1] <= (cro_pkg::CMP_BITS'(dx_c) > cro_pkg::CMP_BITS'(reach_c))
				|| (cro_pkg::CMP_BITS'(dy_c) > cro_pkg::CMP_BITS'(reach_c));
		end
		for (int k = 2; k <= S_ALPHA - 1; k++) begin
			if (en[k]) begin
				far_q[k] <= far_q[k-1];
			end
		end
	end

	// Stage 2: squares; offsets outside the window are cut and later ignored
	logic [cro_pkg::REACH_BITS-1:0] dxn_c;
	logic [cro_pkg::REACH_BITS-1:0] dyn_c;
	logic [cro_pkg::SQ_BITS-1:0]    sqx_s2;
	logic [cro_pkg::SQ_BITS-1:0]    sqy_s2;

	assign dxn_c = cro_pkg::REACH_BITS'(dx_s1);
	assign dyn_c = cro_pkg::REACH_BITS'(dy_s1);

	always_ff @(posedge clk) begin
		if (en[S_SQ]) begin
			sqx_s2 <= cro_pkg::SQ_BITS'(dxn_c) * cro_pkg::SQ_BITS'(dxn_c);
			sqy_s2 <= cro_pkg::SQ_BITS'(dyn_c) * cro_pkg::SQ_BITS'(dyn_c);
		end
	end

	// Stage 3: sum of squares, scaled for the fraction bits of the root
	cro_pkg::sqrt_t root_s3;
	logic [cro_pkg::SUM_BITS-1:0] sum_c;

	assign sum_c = cro_pkg::SUM_BITS'(sqx_s2) + cro_pkg::SUM_BITS'(sqy_s2);

	always_ff @(posedge clk) begin
		if (en[S_SUM]) begin
			root_s3.rad  <= cro_pkg::RAD_N_BITS'(sum_c) << (2 * cro_pkg::DIST_FRAC_BITS);
			root_s3.rem  <= '0;
			root_s3.root <= '0;
		end
	end

	// Root stages: a group of digits each
	cro_pkg::sqrt_t root_q [cro_pkg::SQRT_STAGES];

	for (genvar j = 0; j < cro_pkg::SQRT_STAGES; j++) begin : g_root
		cro_pkg::sqrt_t prev;
		if (j == 0) begin : g_first
			assign prev = root_s3;
		end else begin : g_next
			assign prev = root_q[j-1];
		end
		always_ff @(posedge clk) begin
			if (en[S_ROOT+j]) begin
				root_q[j] <= cro_pkg::sqrt_stage(prev, j * cro_pkg::ITER_PER_STAGE);
			end
		end
	end

	// Alpha stage: stroke error against radius and fade
	logic [cro_pkg::ROOT_BITS-1:0]   dist_c;
	logic [cro_pkg::ROOT_BITS-1:0]   rq_c;
	logic [cro_pkg::ROOT_BITS-1:0]   err_c;
	logic [cro_pkg::ROOT_BITS-1:0]   fade_full_c;
	logic [cro_pkg::FADE_BITS-1:0]   fade_c;
	logic [cro_pkg::FADE_BITS+CW-1:0] fade_prod_c;
	logic [CW-1:0]                   alpha_c;
	logic [CW-1:0]                   alpha_s8;

	always_comb begin
		dist_c      = root_q[cro_pkg::SQRT_STAGES-1].root;
		rq_c        = cro_pkg::ROOT_BITS'(ring_radius_q) << cro_pkg::DIST_FRAC_BITS;
		err_c       = (dist_c >= rq_c) ? dist_c - rq_c : rq_c - dist_c;
		fade_full_c = cro_pkg::ROOT_BITS'(cro_pkg::HALF_STROKE + cro_pkg::FEATHER) - err_c;
		fade_c      = cro_pkg::FADE_BITS'(fade_full_c);
		// times 255 as a shift and subtract, then divide by the feather width
		fade_prod_c = ((cro_pkg::FADE_BITS + CW)'(fade_c) << CW)
			- (cro_pkg::FADE_BITS + CW)'(fade_c);
		if (far_q[S_ALPHA-1]) begin
			alpha_c = '0;
		end else if (err_c <= cro_pkg::ROOT_BITS'(cro_pkg::HALF_STROKE)) begin
			alpha_c = CW'(cro_pkg::CHAN_MAX);
		end else if (err_c >= cro_pkg::ROOT_BITS'(cro_pkg::HALF_STROKE + cro_pkg::FEATHER)) begin
			alpha_c = '0;
		end else begin
			alpha_c = CW'(fade_prod_c >> (cro_pkg::DIST_FRAC_BITS + 1));
		end
	end

	always_ff @(posedge clk) begin
		if (en[S_ALPHA]) begin
			alpha_s8 <= alpha_c;
		end
	end

	// Mix stage: weighted sums per channel and blend kind
	logic [2*CW-1:0]  mix_red_s9;
	logic [2*CW-1:0]  mix_green_s9;
	logic [2*CW-1:0]  mix_blue_s9;
	cro_pkg::blend_t  mode_s9;
	logic [CW-1:0]    inv_alpha_c;
	cro_pkg::pix_t    pix_mix_c;

	assign inv_alpha_c = CW'(cro_pkg::CHAN_MAX) - alpha_s8;
	assign pix_mix_c   = pix_q[S_ALPHA];

	always_ff @(posedge clk) begin
		if (en[S_MIX]) begin
			mix_red_s9   <= (2 * CW)'(ring_red_q) * (2 * CW)'(alpha_s8)
				+ (2 * CW)'(pix_mix_c.red) * (2 * CW)'(inv_alpha_c);
			mix_green_s9 <= (2 * CW)'(ring_green_q) * (2 * CW)'(alpha_s8)
				+ (2 * CW)'(pix_mix_c.green) * (2 * CW)'(inv_alpha_c);
			mix_blue_s9  <= (2 * CW)'(ring_blue_q) * (2 * CW)'(alpha_s8)
				+ (2 * CW)'(pix_mix_c.blue) * (2 * CW)'(inv_alpha_c);
			if (alpha_s8 == CW'(cro_pkg::CHAN_MAX)) begin
				mode_s9 <= cro_pkg::BL_FULL;
			end else if (alpha_s8 == '0) begin
				mode_s9 <= cro_pkg::BL_PASS;
			end else begin
				mode_s9 <= cro_pkg::BL_MIX;
			end
		end
	end

	// Output stage: divide by 255 and select the result
	cro_pkg::pix_t out_c;
	cro_pkg::pix_t out_s10;
	cro_pkg::pix_t pix_out_c;

	assign pix_out_c = pix_q[S_MIX];

	always_comb begin
		case (mode_s9)
			cro_pkg::BL_FULL: begin
				out_c.red   = ring_red_q;
				out_c.green = ring_green_q;
				out_c.blue  = ring_blue_q;
				out_c.alpha = CW'(cro_pkg::CHAN_MAX);
			end
			cro_pkg::BL_MIX: begin
				out_c.red   = cro_pkg::div255(mix_red_s9);
				out_c.green = cro_pkg::div255(mix_green_s9);
				out_c.blue  = cro_pkg::div255(mix_blue_s9);
				out_c.alpha = CW'(cro_pkg::CHAN_MAX);
			end
			default: begin
				out_c = pix_out_c;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[STAGES]) begin
			out_s10 <= out_c;
		end
	end

	assign m_tdata = {out_s10.alpha, out_s10.blue, out_s10.green, out_s10.red};

	// A ready output lets the whole pipe move
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output is ready");

	// Pixels outside the window get no ring
	a_far_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(en[S_ALPHA] && valid_q[S_ALPHA-1] && far_q[S_ALPHA-1]) |=> (alpha_s8 == '0))
		else $error("ring alpha set outside the window");

	// Full coverage selects the ring colour
	a_full_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(en[S_MIX] && valid_q[S_ALPHA] && alpha_s8 == CW'(cro_pkg::CHAN_MAX))
		|=> (mode_s9 == cro_pkg::BL_FULL))
		else $error("full alpha not blended as ring colour");

	// Pass-through keeps the incoming pixel
	a_pass_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(en[STAGES] && valid_q[S_MIX] && mode_s9 == cro_pkg::BL_PASS)
		|=> (out_s10 == $past(pix_out_c)))
		else $error("pass-through pixel altered");

endmodule

// ===== dv/cursor_ring_overlay_top_test.sv =====
`timescale 1ns / 1ps

module cursor_ring_overlay_top_test;

	localparam logic [cro_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam longint unsigned EDGE_HALF = 5 << (cro_pkg::DIST_FRAC_BITS - 2);
	localparam longint unsigned EDGE_FADE = 2 << cro_pkg::DIST_FRAC_BITS;
	localparam int unsigned OPAQUE = 255;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 92;
	localparam int DRAIN_CYCLES = 16;
	localparam int QUIET_LIMIT = 1000;

	// One pixel request, packed in stream order: x lowest, then y, then the pixel
	typedef struct packed {
		cro_pkg::pix_t                  px;
		logic [cro_pkg::COORD_BITS-1:0] y;
		logic [cro_pkg::COORD_BITS-1:0] x;
	} pixel_req_t;

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [cro_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [cro_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [cro_pkg::IN_DATA_W-1:0]   s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [cro_pkg::OUT_DATA_W-1:0]  m_tdata;

	// Ring settings as the block should hold them
	logic [cro_pkg::COORD_BITS-1:0]  ring_cx = '0;
	logic [cro_pkg::COORD_BITS-1:0]  ring_cy = '0;
	logic [cro_pkg::RAD_BITS-1:0]    ring_rad = 16;
	logic [cro_pkg::CHAN_BITS-1:0]   ring_r = '0;
	logic [cro_pkg::CHAN_BITS-1:0]   ring_g = '0;
	logic [cro_pkg::CHAN_BITS-1:0]   ring_b = '0;

	pixel_req_t    pixel_q[$];
	cro_pkg::pix_t blended_q[$];
	pixel_req_t    cur_req;
	logic          src_busy = 1'b0;
	int            src_gap = 0;
	int            sink_gap = 0;
	logic          steady = 1'b0;
	cro_pkg::pix_t got_px;
	cro_pkg::pix_t want_px;
	int            errors = 0;
	int            n_sent = 0;
	int            n_checked = 0;
	int            n_settings = 0;
	int            n_full = 0;
	int            n_mix = 0;
	int            n_pass = 0;
	int            quiet_cycles = 0;

	cursor_ring_overlay_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		errors++;
		$display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
	endtask

	// Floor of the square root, one result bit at a time from the top
	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= n) r = t;
		end
		return r;
	endfunction

	// Ring alpha from the fixed-point distance to the centre
	function automatic int unsigned ring_coverage(logic [cro_pkg::COORD_BITS-1:0] x,
			logic [cro_pkg::COORD_BITS-1:0] y);
		longint unsigned dx, dy, reach, dist_fx, rq, e;
		dx = (x >= ring_cx) ? x - ring_cx : ring_cx - x;
		dy = (y >= ring_cy) ? y - ring_cy : ring_cy - y;
		reach = 64'(ring_rad) + 4;
		if (dx > reach || dy > reach) return 0;
		dist_fx = root_floor((dx * dx + dy * dy) << (2 * cro_pkg::DIST_FRAC_BITS));
		rq = 64'(ring_rad) << cro_pkg::DIST_FRAC_BITS;
		e = (dist_fx >= rq) ? dist_fx - rq : rq - dist_fx;
		if (e <= EDGE_HALF) return OPAQUE;
		if (e >= EDGE_HALF + EDGE_FADE) return 0;
		return int'(((EDGE_HALF + EDGE_FADE - e) * OPAQUE) / EDGE_FADE);
	endfunction

	function automatic logic [cro_pkg::CHAN_BITS-1:0] blend_chan(int unsigned c,
			int unsigned p, int unsigned a);
		return cro_pkg::CHAN_BITS'((c * a + p * (OPAQUE - a)) / OPAQUE);
	endfunction

	// Expected output pixel for one request under the current ring settings
	function automatic cro_pkg::pix_t overlay_pixel(pixel_req_t req);
		int unsigned a;
		cro_pkg::pix_t res;
		a = ring_coverage(req.x, req.y);
		if (a == OPAQUE) begin
			res.red = ring_r;
			res.green = ring_g;
			res.blue = ring_b;
			res.alpha = cro_pkg::CHAN_BITS'(OPAQUE);
			n_full++;
		end else if (a == 0) begin
			res = req.px;
			n_pass++;
		end else begin
			res.red = blend_chan(ring_r, req.px.red, a);
			res.green = blend_chan(ring_g, req.px.green, a);
			res.blue = blend_chan(ring_b, req.px.blue, a);
			res.alpha = cro_pkg::CHAN_BITS'(OPAQUE);
			n_mix++;
		end
		return res;
	endfunction

	// Present requests in order, predicting each one as it is taken
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			src_busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				blended_q.push_back(overlay_pixel(cur_req));
				n_sent++;
				src_busy = 1'b0;
				src_gap = steady ? 0 : $urandom_range(0, 5);
			end
			if (!src_busy) begin
				if (src_gap > 0) begin
					src_gap--;
				end else if (pixel_q.size() > 0) begin
					cur_req = pixel_q.pop_front();
					s_tdata <= cur_req;
					src_busy = 1'b1;
				end
			end
			s_tvalid <= src_busy;
		end
	end

	// Check each result against the oldest prediction, stall at random
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_px = cro_pkg::pix_t'(m_tdata);
				if (blended_q.size() == 0) begin
					report_mismatch("result with nothing pending", got_px, 0);
				end else begin
					want_px = blended_q.pop_front();
					if (got_px.red !== want_px.red)
						report_mismatch("out_red", got_px.red, want_px.red);
					if (got_px.green !== want_px.green)
						report_mismatch("out_green", got_px.green, want_px.green);
					if (got_px.blue !== want_px.blue)
						report_mismatch("out_blue", got_px.blue, want_px.blue);
					if (got_px.alpha !== want_px.alpha)
						report_mismatch("out_alpha", got_px.alpha, want_px.alpha);
				end
				n_checked++;
				sink_gap = steady ? 0 : $urandom_range(0, 5);
			end else if (sink_gap > 0) begin
				sink_gap--;
			end
			m_tready <= (sink_gap == 0);
		end
	end

	// Abort when no request moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Hold one register write until taken; the caller lowers valid
	task automatic write_reg(logic [cro_pkg::CFG_IDX_W-1:0] idx,
			logic [cro_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			cro_pkg::CFG_CENTER_X:    ring_cx = val;
			cro_pkg::CFG_CENTER_Y:    ring_cy = val;
			cro_pkg::CFG_RING_RADIUS: ring_rad = val[cro_pkg::RAD_BITS-1:0];
			cro_pkg::CFG_RING_RED:    ring_r = val[cro_pkg::CHAN_BITS-1:0];
			cro_pkg::CFG_RING_GREEN:  ring_g = val[cro_pkg::CHAN_BITS-1:0];
			cro_pkg::CFG_RING_BLUE:   ring_b = val[cro_pkg::CHAN_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_ring(logic [cro_pkg::CFG_DATA_W-1:0] cx,
			logic [cro_pkg::CFG_DATA_W-1:0] cy, logic [cro_pkg::CFG_DATA_W-1:0] rad,
			logic [cro_pkg::CFG_DATA_W-1:0] r, logic [cro_pkg::CFG_DATA_W-1:0] g,
			logic [cro_pkg::CFG_DATA_W-1:0] b, bit poke_unused);
		write_reg(cro_pkg::CFG_CENTER_X, cx);
		write_reg(cro_pkg::CFG_CENTER_Y, cy);
		write_reg(cro_pkg::CFG_RING_RADIUS, rad);
		write_reg(cro_pkg::CFG_RING_RED, r);
		write_reg(cro_pkg::CFG_RING_GREEN, g);
		write_reg(cro_pkg::CFG_RING_BLUE, b);
		// an index past the register list must leave every setting alone
		if (poke_unused) write_reg(CFG_UNUSED, '1);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic queue_pixel(logic [cro_pkg::COORD_BITS-1:0] x,
			logic [cro_pkg::COORD_BITS-1:0] y, cro_pkg::pix_t px);
		pixel_q.push_back(pixel_req_t'({px, y, x}));
	endtask

	// Point close to the ring stroke, in a random octant
	task automatic queue_near();
		int unsigned rad, a, b, t;
		logic [cro_pkg::COORD_BITS-1:0] x, y;
		rad = 32'(ring_rad);
		a = $urandom_range(0, rad + 5);
		b = (a <= rad) ? 32'(root_floor(rad * rad - a * a)) : 0;
		b = b + $urandom_range(0, 8);
		b = (b >= 4) ? b - 4 : 0;
		if ($urandom_range(0, 1)) begin
			t = a;
			a = b;
			b = t;
		end
		x = $urandom_range(0, 1) ? cro_pkg::COORD_BITS'(ring_cx + a)
			: cro_pkg::COORD_BITS'(ring_cx - a);
		y = $urandom_range(0, 1) ? cro_pkg::COORD_BITS'(ring_cy + b)
			: cro_pkg::COORD_BITS'(ring_cy - b);
		queue_pixel(x, y, cro_pkg::pix_t'($urandom));
	endtask

	function automatic logic [cro_pkg::COORD_BITS-1:0] pick_coord();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return cro_pkg::COORD_BITS'($urandom);
		endcase
	endfunction

	// Wait until every request has been taken and answered, then let the pipe drain
	task automatic settle();
		while (pixel_q.size() != 0 || src_busy || blended_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [cro_pkg::CFG_DATA_W-1:0] rad;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: centre at the origin, radius 16, black
		queue_pixel(0, 0, cro_pkg::pix_t'(32'h5AFF00FF));
		queue_pixel(16, 0, cro_pkg::pix_t'(32'h00FFFFFF));
		queue_pixel(17, 0, cro_pkg::pix_t'(32'h12345678));
		queue_pixel(0, 18, cro_pkg::pix_t'(32'hFFFFFFFF));
		queue_pixel(19, 0, cro_pkg::pix_t'(32'h80C0E0F0));
		queue_pixel(20, 0, cro_pkg::pix_t'(32'hA5A5A5A5));
		queue_pixel(21, 0, cro_pkg::pix_t'(32'h3C3C3C3C));
		queue_pixel('1, '1, cro_pkg::pix_t'(32'h00FF00FF));
		settle();

		// Radius one: the centre sits inside the solid stroke
		apply_ring(2048, 1024, 1, 255, 0, 170, 1'b1);
		queue_pixel(2048, 1024, cro_pkg::pix_t'(32'h11223344));
		queue_pixel(2049, 1024, cro_pkg::pix_t'(32'h00000000));
		queue_pixel(2050, 1025, cro_pkg::pix_t'(32'hFFFFFFFF));
		queue_pixel(2051, 1024, cro_pkg::pix_t'(32'h7F7F7F7F));
		queue_pixel(2045, 1021, cro_pkg::pix_t'(32'h0000FF00));
		queue_pixel(2052, 1024, cro_pkg::pix_t'(32'hC0FFEE00));
		settle();

		apply_ring(2048, 1024, 0, 12, 34, 56, 1'b0);
		queue_pixel(2048, 1024, cro_pkg::pix_t'(32'h99887766));
		queue_pixel(2051, 1027, cro_pkg::pix_t'(32'h55443322));
		settle();

		// Largest centre and radius, white ring
		apply_ring('1, '1, 1023, 255, 255, 255, 1'b0);
		queue_pixel(3072, '1, cro_pkg::pix_t'(32'h01020304));
		queue_pixel(0, 0, cro_pkg::pix_t'(32'hFEFDFCFB));
		queue_pixel(3069, '1, cro_pkg::pix_t'(32'h00000000));
		queue_pixel('1, 3072, cro_pkg::pix_t'(32'h80808080));
		settle();

		// Random ring settings, mostly points around the stroke
		for (int p = 0; p < PHASES; p++) begin
			steady = (p % 3 == 2);
			if (p == 3) rad = 1023;
			else if (p == 6) rad = 0;
			else rad = cro_pkg::CFG_DATA_W'($urandom_range(1, 48));
			rad[cro_pkg::CFG_DATA_W-1:cro_pkg::RAD_BITS] =
				(cro_pkg::CFG_DATA_W - cro_pkg::RAD_BITS)'($urandom);
			apply_ring(pick_coord(), pick_coord(), rad, cro_pkg::CFG_DATA_W'($urandom),
				cro_pkg::CFG_DATA_W'($urandom), cro_pkg::CFG_DATA_W'($urandom), p == 5);
			repeat (ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 4) == 0)
					queue_pixel(cro_pkg::COORD_BITS'($urandom),
						cro_pkg::COORD_BITS'($urandom), cro_pkg::pix_t'($urandom));
				else
					queue_near();
			end
			settle();
		end

		if (blended_q.size() != 0)
			report_mismatch("results never delivered", blended_q.size(), 0);
		$display("%0d pixels over %0d ring settings, %0d results checked, %0d mismatches",
			n_sent, n_settings, n_checked, errors);
		$display("coverage: %0d solid ring, %0d feathered blend, %0d passed through",
			n_full, n_mix, n_pass);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/cro_pkg.sv
src/cursor_ring_overlay_top.sv
dv/cursor_ring_overlay_top_test.sv
